// ===== hw/rtl/pdm_pkg.sv =====
// Shared types, codes and constants for the PWM duty cycle meter.
// No dependencies; imported by every module of the block.
package pdm_pkg;

  localparam int TS_FIELD_W = 16;
  localparam int KIND_W     = 2;
  localparam int DUTY_W     = 7;
  localparam int CHAR_W     = 6;

  // event codes
  localparam logic [KIND_W-1:0] EVT_FALL = 2'd0;
  localparam logic [KIND_W-1:0] EVT_RISE = 2'd1;
  localparam logic [KIND_W-1:0] EVT_TICK = 2'd2;

  // result codes
  localparam logic [KIND_W-1:0] RES_UPDATED = 2'd0;
  localparam logic [KIND_W-1:0] RES_SHOW    = 2'd1;
  localparam logic [KIND_W-1:0] RES_IDLE    = 2'd2;

  localparam logic [DUTY_W-1:0] PCT_SCALE   = 7'd100;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'h30;
  localparam logic [CHAR_W-1:0] ASCII_BLANK = 6'h20;
  localparam logic [DUTY_W-1:0] DEC_BASE    = 7'd10;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] quot;
  } div_status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] tens;
    logic [CHAR_W-1:0] units;
  } digit_pair_t;

  // Two ASCII digits of a 0..100 value; 100 wraps to "00".
  function automatic digit_pair_t duty_digits(input logic [DUTY_W-1:0] d);
    logic [3:0]        t;
    logic [DUTY_W-1:0] u;
    digit_pair_t       r;
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (d >= DUTY_W'(i * 10)) t = 4'(i);
    end
    u = d - DUTY_W'({3'b0, t} * DEC_BASE);
    if (d >= PCT_SCALE) begin
      t = 4'd0;
      u = '0;
    end
    r.tens  = ASCII_ZERO + CHAR_W'(t);
    r.units = ASCII_ZERO + u[CHAR_W-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/pdm_div.sv =====
// Bit-serial restoring divider: (a * 100) / den, one quotient bit per cycle.
// Depends on pdm_pkg. Caller guarantees a < den, so the quotient is below 100.
module pdm_div #(
  parameter int TS_W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TS_W-1:0]      a,
  input  logic [TS_W-1:0]      den,
  output pdm_pkg::div_status_t status
);
  import pdm_pkg::*;

  localparam int NUM_W = TS_W + DUTY_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_sh;
  logic [TS_W-1:0]   rem;
  logic [TS_W-1:0]   den_r;
  logic [DUTY_W-1:0] quot;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [NUM_W-1:0]  num_init;
  logic [TS_W:0]     rem_sh;
  logic              q_bit;
  logic [TS_W:0]     rem_sub;

  // a*100 = a*64 + a*32 + a*4
  assign num_init = (NUM_W'(a) << 6) + (NUM_W'(a) << 5) + (NUM_W'(a) << 2);

  assign rem_sh  = {rem, num_sh[NUM_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num_init;
      rem    <= '0;
      den_r  <= den;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= q_bit ? rem_sub[TS_W-1:0] : rem_sh[TS_W-1:0];
      quot   <= {quot[DUTY_W-2:0], q_bit};
    end
  end

  assign status.done = done;
  assign status.quot = quot;

endmodule

// ===== hw/rtl/pwm_duty_cycle_meter_unit.sv =====
// PWM low-time duty meter, top level.
// Depends on pdm_pkg and pdm_div.
//
// Input channel (in_valid / in_stall): event_kind and timestamp of a falling
// edge, rising edge or one-second tick. Output channel (out_valid /
// out_stall): result_kind, duty_percent and two ASCII digits.
// A rising edge or an unproductive item leaves the unit idle and gives no result.
// A tick that is armed gives its result through S_EMIT to the output register.
// A falling edge that yields a new duty runs the serial divider, one
// quotient bit per cycle over TS_W+7 bits (at most 16+7), and its result
// passes through S_EMIT to the output register; a ratio of one or more
// skips the divider and saturates to 100.
// One item is in work at a time: in_stall is high from the transfer until
// the result is loaded into the output register. A finished result waits in
// that register while out_stall is high, and the next item may already be
// taken meanwhile; a following result waits until the register frees.
// Reset clears all timestamps, the duty and the arming, and empties the
// output register.
module pwm_duty_cycle_meter_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pdm_pkg::KIND_W-1:0]     event_kind,
  input  logic [pdm_pkg::TS_FIELD_W-1:0] timestamp,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pdm_pkg::KIND_W-1:0]     result_kind,
  output logic [pdm_pkg::DUTY_W-1:0]     duty_percent,
  output logic [pdm_pkg::CHAR_W-1:0]     tens_char,
  output logic [pdm_pkg::CHAR_W-1:0]     units_char
);
  import pdm_pkg::*;

  localparam int TS_W = (TIMER_BITS < TS_FIELD_W) ? TIMER_BITS : TS_FIELD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]        state;
  logic [TS_W-1:0]   last_fall_time;
  logic [TS_W-1:0]   last_rise_time;
  logic [TS_W-1:0]   rise_time_at_tick;
  logic [DUTY_W-1:0] duty_value;
  logic              tick_armed;
  logic [KIND_W-1:0] pend_kind;
  logic [DUTY_W-1:0] pend_duty;

  logic              in_xfer;
  logic              out_free;
  logic [TS_W-1:0]   ts;
  logic              fall_ok;
  logic              fall_sat;
  logic              div_start;
  div_status_t       div_st;
  digit_pair_t       digits;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign ts       = timestamp[TS_W-1:0];

  assign fall_ok   = (ts > last_fall_time) && (last_rise_time > last_fall_time);
  // rise at or after the new fall means a ratio of at least one
  assign fall_sat  = (last_rise_time >= ts);
  assign div_start = in_xfer && (event_kind == EVT_FALL) && fall_ok && !fall_sat;

  pdm_div #(
    .TS_W (TS_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .a      (last_rise_time - last_fall_time),
    .den    (ts - last_fall_time),
    .status (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      last_fall_time    <= '0;
      last_rise_time    <= '0;
      rise_time_at_tick <= '0;
      duty_value        <= '0;
      tick_armed        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (event_kind)
              EVT_FALL: begin
                last_fall_time <= ts;
                if (fall_ok) begin
                  tick_armed <= 1'b1;
                  if (fall_sat) begin
                    duty_value <= PCT_SCALE;
                    pend_kind  <= RES_UPDATED;
                    pend_duty  <= PCT_SCALE;
                    state      <= S_EMIT;
                  end else begin
                    state <= S_DIV;
                  end
                end
              end
              EVT_RISE: last_rise_time <= ts;
              EVT_TICK: begin
                if (tick_armed) begin
                  rise_time_at_tick <= last_rise_time;
                  state             <= S_EMIT;
                  if (rise_time_at_tick != last_rise_time) begin
                    pend_kind <= RES_SHOW;
                    pend_duty <= duty_value;
                  end else begin
                    pend_kind  <= RES_IDLE;
                    pend_duty  <= '0;
                    duty_value <= '0;
                    tick_armed <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            duty_value <= div_st.quot;
            pend_kind  <= RES_UPDATED;
            pend_duty  <= div_st.quot;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digits = duty_digits(pend_duty);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      result_kind  <= pend_kind;
      duty_percent <= pend_duty;
      if (pend_kind == RES_IDLE) begin
        tens_char  <= ASCII_BLANK;
        units_char <= ASCII_BLANK;
      end else begin
        tens_char  <= digits.tens;
        units_char <= digits.units;
      end
    end
  end

endmodule

// ===== hw/rtl/pdm_checker.sv =====
// Port-level checks on the duty meter's result channel.
// Depends on pdm_pkg; bound to pwm_duty_cycle_meter_unit below.
module pdm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pdm_pkg::KIND_W-1:0]     result_kind,
  input logic [pdm_pkg::DUTY_W-1:0]     duty_percent,
  input logic [pdm_pkg::CHAR_W-1:0]     tens_char,
  input logic [pdm_pkg::CHAR_W-1:0]     units_char
);
  import pdm_pkg::*;

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(duty_percent))
    else $error("stalled result changed");

  a_idle_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RES_IDLE |->
      duty_percent == '0 && tens_char == ASCII_BLANK && units_char == ASCII_BLANK)
    else $error("idle result not blank");

  a_duty_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RES_UPDATED || result_kind == RES_SHOW) |->
      duty_percent <= PCT_SCALE && {tens_char, units_char} == duty_digits(duty_percent))
    else $error("digits do not match duty");

endmodule

bind pwm_duty_cycle_meter_unit pdm_checker u_pdm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_kind  (result_kind),
  .duty_percent (duty_percent),
  .tens_char    (tens_char),
  .units_char   (units_char)
);
